### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file svsa_checker.sv.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A condition that, once seen, implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/svsa_pkg.sv
// ---------------------------------------------------------------------------
// svsa_pkg
// Widths, codes, bounds and the per-channel update rule of the sustained
// vital-sign alarm.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package svsa_pkg;

    // Field widths.
    localparam int STAMP_W = 32;
    localparam int ACT_W   = 3;
    localparam int VAL_W   = 12;
    localparam int BOUND_W = 8;
    localparam int COUNT_W = 8;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 4;

    // Alert rule.
    localparam logic [COUNT_W-1:0] ALERT_COUNT   = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;
    localparam logic [STAMP_W-1:0] SUSTAIN_LIMIT = 32'd30;

    // Fixed heart-rate bounds for any other activity.
    localparam logic [BOUND_W-1:0] OTHER_LOW  = 8'd0;
    localparam logic [BOUND_W-1:0] OTHER_HIGH = 8'd220;

    // Activity codes.
    localparam logic [ACT_W-1:0] ACT_WALKING  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SITTING  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STANDING = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LYING    = 3'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_NORMAL = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LOW    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_HIGH   = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LYING_LOW    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LYING_HIGH   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEATED_LOW   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEATED_HIGH  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALKING_LOW  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WALKING_HIGH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLD         = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOT          = 4'd7;

    // Register reset values.
    localparam logic [BOUND_W-1:0] RST_LYING_LOW    = 8'd48;
    localparam logic [BOUND_W-1:0] RST_LYING_HIGH   = 8'd128;
    localparam logic [BOUND_W-1:0] RST_SEATED_LOW   = 8'd90;
    localparam logic [BOUND_W-1:0] RST_SEATED_HIGH  = 8'd135;
    localparam logic [BOUND_W-1:0] RST_WALKING_LOW  = 8'd128;
    localparam logic [BOUND_W-1:0] RST_WALKING_HIGH = 8'd142;
    localparam logic [BOUND_W-1:0] RST_COLD         = 8'd10;
    localparam logic [BOUND_W-1:0] RST_HOT          = 8'd30;

    // State of one out-of-range channel.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] start;
    } chan_t;

    // Updated channel state and its alert flag.
    typedef struct packed {
        chan_t chan;
        logic  alert;
    } chan_upd_t;

    // Apply one breaking sample to a channel.
    function automatic chan_upd_t chan_hit(input chan_t cur, input logic [STAMP_W-1:0] stamp);
        chan_upd_t          res;
        logic [COUNT_W-1:0] cnt;
        logic [STAMP_W-1:0] elapsed;
        cnt     = (cur.count != COUNT_MAX) ? cur.count + 8'd1 : cur.count;
        elapsed = stamp - cur.start;
        res.chan.count = cnt;
        res.chan.start = cur.start;
        res.alert      = 1'b0;
        if (cnt == 8'd1)
        begin
            res.chan.start = stamp;
        end
        else if (cnt == ALERT_COUNT && elapsed <= SUSTAIN_LIMIT)
        begin
            res.alert = 1'b1;
        end
        else if (elapsed > SUSTAIN_LIMIT)
        begin
            res.chan.count = '0;
        end
        return res;
    endfunction

endpackage

### rtl/sustained_vital_sign_alarm_top.sv
// ---------------------------------------------------------------------------
// sustained_vital_sign_alarm_top
// A record is registered in the input register, then its status in the
// result register, which holds it until the result side takes it.
// Throughput: one record per cycle unless the result side stalls, set by
// the single compare-and-update stage between the two registers.
// Reset: asynchronous, active low; clears all channel counts and start
// stamps, empties both stages and restores the bound registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sustained_vital_sign_alarm_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input record channel.
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [svsa_pkg::STAMP_W-1:0]          stamp,
    input  logic [svsa_pkg::ACT_W-1:0]            activity_code,
    input  logic [svsa_pkg::VAL_W-1:0]            pulse_q4,
    input  logic signed [svsa_pkg::VAL_W-1:0]     temperature_q4,
    // Result channel.
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [svsa_pkg::STAT_W-1:0]           pulse_status,
    output logic [svsa_pkg::STAT_W-1:0]           temperature_status,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [svsa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [svsa_pkg::BOUND_W-1:0]          cfg_data
);
    import svsa_pkg::*;

    // Bound registers.
    logic [BOUND_W-1:0] lying_low_reg, lying_high_reg;
    logic [BOUND_W-1:0] seated_low_reg, seated_high_reg;
    logic [BOUND_W-1:0] walking_low_reg, walking_high_reg;
    logic [BOUND_W-1:0] cold_reg, hot_reg;

    // Input stage.
    logic                      s1_valid_reg;
    logic [STAMP_W-1:0]        stamp_reg;
    logic [ACT_W-1:0]          act_reg;
    logic [VAL_W-1:0]          pulse_reg;
    logic signed [VAL_W-1:0]   temp_reg;

    // Channel state.
    chan_t low_pulse_reg, high_pulse_reg, cold_ch_reg, hot_ch_reg;
    chan_t low_pulse_next, high_pulse_next, cold_ch_next, hot_ch_next;

    // Result stage.
    logic                out_valid_reg;
    logic [STAT_W-1:0]   pstat_reg, tstat_reg;
    logic [STAT_W-1:0]   pstat_next, tstat_next;

    // Handshake.
    logic out_free;
    logic advance;
    logic in_xfer;

    // Compare-and-update signals.
    logic [BOUND_W-1:0]        lo_bound, hi_bound;
    logic [VAL_W-1:0]          lo_q4, hi_q4;
    logic signed [VAL_W-1:0]   cold_q4, hot_q4;
    chan_upd_t                 low_pulse_upd, high_pulse_upd, cold_upd, hot_upd;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    assign out_valid          = out_valid_reg;
    assign pulse_status       = pstat_reg;
    assign temperature_status = tstat_reg;

    // Heart-rate bounds chosen by the activity.
    always_comb
    begin
        case (act_reg)
            ACT_WALKING:
            begin
                lo_bound = walking_low_reg;
                hi_bound = walking_high_reg;
            end
            ACT_SITTING, ACT_STANDING:
            begin
                lo_bound = seated_low_reg;
                hi_bound = seated_high_reg;
            end
            ACT_LYING:
            begin
                lo_bound = lying_low_reg;
                hi_bound = lying_high_reg;
            end
            default:
            begin
                lo_bound = OTHER_LOW;
                hi_bound = OTHER_HIGH;
            end
        endcase
    end

    // Whole-unit bounds scaled to the four-fraction-bit sample format.
    assign lo_q4   = {lo_bound, 4'b0000};
    assign hi_q4   = {hi_bound, 4'b0000};
    assign cold_q4 = $signed({cold_reg, 4'b0000});
    assign hot_q4  = $signed({hot_reg, 4'b0000});

    assign low_pulse_upd  = chan_hit(low_pulse_reg, stamp_reg);
    assign high_pulse_upd = chan_hit(high_pulse_reg, stamp_reg);
    assign cold_upd       = chan_hit(cold_ch_reg, stamp_reg);
    assign hot_upd        = chan_hit(hot_ch_reg, stamp_reg);

    // Heart-rate channels: the low bound takes priority when both break.
    always_comb
    begin
        low_pulse_next  = low_pulse_reg;
        high_pulse_next = high_pulse_reg;
        pstat_next      = STAT_NORMAL;
        if (pulse_reg < lo_q4)
        begin
            low_pulse_next = low_pulse_upd.chan;
            if (low_pulse_upd.alert)
            begin
                pstat_next = STAT_LOW;
            end
        end
        else if (pulse_reg > hi_q4)
        begin
            high_pulse_next = high_pulse_upd.chan;
            if (high_pulse_upd.alert)
            begin
                pstat_next = STAT_HIGH;
            end
        end
    end

    // Temperature channels: the cold bound takes priority when both break.
    always_comb
    begin
        cold_ch_next = cold_ch_reg;
        hot_ch_next  = hot_ch_reg;
        tstat_next   = STAT_NORMAL;
        if (temp_reg < cold_q4)
        begin
            cold_ch_next = cold_upd.chan;
            if (cold_upd.alert)
            begin
                tstat_next = STAT_LOW;
            end
        end
        else if (temp_reg > hot_q4)
        begin
            hot_ch_next = hot_upd.chan;
            if (hot_upd.alert)
            begin
                tstat_next = STAT_HIGH;
            end
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lying_low_reg    <= RST_LYING_LOW;
            lying_high_reg   <= RST_LYING_HIGH;
            seated_low_reg   <= RST_SEATED_LOW;
            seated_high_reg  <= RST_SEATED_HIGH;
            walking_low_reg  <= RST_WALKING_LOW;
            walking_high_reg <= RST_WALKING_HIGH;
            cold_reg         <= RST_COLD;
            hot_reg          <= RST_HOT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LYING_LOW:    lying_low_reg    <= cfg_data;
                REG_LYING_HIGH:   lying_high_reg   <= cfg_data;
                REG_SEATED_LOW:   seated_low_reg   <= cfg_data;
                REG_SEATED_HIGH:  seated_high_reg  <= cfg_data;
                REG_WALKING_LOW:  walking_low_reg  <= cfg_data;
                REG_WALKING_HIGH: walking_high_reg <= cfg_data;
                REG_COLD:         cold_reg         <= cfg_data;
                REG_HOT:          hot_reg          <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stamp_reg <= stamp;
            act_reg   <= activity_code;
            pulse_reg <= pulse_q4;
            temp_reg  <= temperature_q4;
        end
    end

    // Channel state update, once per record leaving the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_pulse_reg  <= '0;
            high_pulse_reg <= '0;
            cold_ch_reg    <= '0;
            hot_ch_reg     <= '0;
        end
        else if (advance)
        begin
            low_pulse_reg  <= low_pulse_next;
            high_pulse_reg <= high_pulse_next;
            cold_ch_reg    <= cold_ch_next;
            hot_ch_reg     <= hot_ch_next;
        end
    end

    // Result stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pstat_reg <= pstat_next;
            tstat_reg <= tstat_next;
        end
    end

endmodule

### rtl/svsa_checker.sv
// ---------------------------------------------------------------------------
// svsa_checker
// Port-level checks of the sustained vital-sign alarm, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svsa_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [svsa_pkg::STAT_W-1:0]       pulse_status,
    input logic [svsa_pkg::STAT_W-1:0]       temperature_status
);
    import svsa_pkg::*;

    // The input side only stalls when a result is held back downstream.
    `ASSERT_ALWAYS(a_stall_cause, clk, rst_n, !in_stall || (out_valid && out_stall),
                   "input stall without a held result")

    // Status codes stay within normal, low and high.
    `ASSERT_ALWAYS(a_pulse_code, clk, rst_n, pulse_status <= STAT_HIGH,
                   "invalid pulse status code")
    `ASSERT_ALWAYS(a_temp_code, clk, rst_n, temperature_status <= STAT_HIGH,
                   "invalid temperature status code")

    // A stalled result stays in place unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(pulse_status) && $stable(temperature_status),
                 "stalled result changed")

endmodule

bind sustained_vital_sign_alarm_top svsa_checker u_svsa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .pulse_status       (pulse_status),
    .temperature_status (temperature_status)
);

### bench/sustained_vital_sign_alarm_top_test.sv
// ---------------------------------------------------------------------------
// sustained_vital_sign_alarm_top_test
// Self-checking bench for the sustained vital-sign alarm. A behavioral copy
// of the four out-of-range channels predicts the status of every accepted
// record. A checker compares each result transfer with the oldest
// prediction. Named tests cover field extremes, the sustain window,
// count saturation, bound extremes, back-pressure and random record bursts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sustained_vital_sign_alarm_top_test;

    import svsa_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int PHASE_RECORDS     = 85;
    localparam int MAX_ERROR_LINES   = 30;
    localparam int PULSE_MAX         = 4095;
    localparam int TEMP_MIN          = -2048;
    localparam int TEMP_MAX          = 2047;

    // Activity codes that select the fixed heart-rate bounds.
    localparam logic [ACT_W-1:0] ACT_OTHER_FIRST = 3'd4;
    localparam logic [ACT_W-1:0] ACT_OTHER_LAST  = 3'd7;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;

    typedef logic [BOUND_W-1:0] bound_set_t [8];

    localparam bound_set_t DEFAULT_BOUNDS = '{RST_LYING_LOW, RST_LYING_HIGH,
        RST_SEATED_LOW, RST_SEATED_HIGH, RST_WALKING_LOW, RST_WALKING_HIGH,
        RST_COLD, RST_HOT};

    // Where a generated value should land relative to the bounds.
    typedef enum int {AIM_ANY, AIM_LOW, AIM_HIGH, AIM_INSIDE} aim_t;

    typedef struct {
        logic [STAMP_W-1:0]        stamp;
        logic [ACT_W-1:0]          activity;
        logic [VAL_W-1:0]          pulse;
        logic signed [VAL_W-1:0]   temperature;
    } record_t;

    typedef struct {
        logic [STAT_W-1:0] pulse;
        logic [STAT_W-1:0] temperature;
    } status_pair_t;

    typedef struct {
        logic [COUNT_W-1:0] hits;
        logic [STAMP_W-1:0] first_stamp;
    } alarm_channel_t;

    // Block ports.
    logic                      clk;
    logic                      rst_n          = 1'b0;
    logic                      in_valid       = 1'b0;
    logic                      in_stall;
    logic [STAMP_W-1:0]        stamp          = '0;
    logic [ACT_W-1:0]          activity_code  = '0;
    logic [VAL_W-1:0]          pulse_q4       = '0;
    logic signed [VAL_W-1:0]   temperature_q4 = '0;
    logic                      out_valid;
    logic                      out_stall      = 1'b0;
    logic [STAT_W-1:0]         pulse_status;
    logic [STAT_W-1:0]         temperature_status;
    logic                      cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [BOUND_W-1:0]        cfg_data       = '0;

    // Predictor state: bound registers and the four channels.
    bound_set_t      bound_reg     = DEFAULT_BOUNDS;
    alarm_channel_t  low_pulse_ch  = '{default: '0};
    alarm_channel_t  high_pulse_ch = '{default: '0};
    alarm_channel_t  cold_ch       = '{default: '0};
    alarm_channel_t  hot_ch        = '{default: '0};

    // Predicted statuses waiting for their result transfer.
    status_pair_t    expected_status [$];

    int              error_count  = 0;
    int              cycle_count  = 0;
    int              hold_request = 0;
    int              hold_left    = 0;
    bit              steady_flow  = 1'b0;

    sustained_vital_sign_alarm_top u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .stamp              (stamp),
        .activity_code      (activity_code),
        .pulse_q4           (pulse_q4),
        .temperature_q4     (temperature_q4),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .pulse_status       (pulse_status),
        .temperature_status (temperature_status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic flag_error(input string what, input int want, input int got);
        error_count++;
        if (error_count <= MAX_ERROR_LINES)
        begin
            $display("ERROR cycle %0d: %s expected %0d got %0d", cycle_count, what,
                     want, got);
        end
    endtask

    // Heart-rate bounds, in whole beats per minute, for an activity code.
    function automatic void heart_bounds(input logic [ACT_W-1:0] act, output int lo,
                                         output int hi);
        case (act)
            ACT_WALKING:
            begin
                lo = bound_reg[REG_WALKING_LOW];
                hi = bound_reg[REG_WALKING_HIGH];
            end
            ACT_SITTING, ACT_STANDING:
            begin
                lo = bound_reg[REG_SEATED_LOW];
                hi = bound_reg[REG_SEATED_HIGH];
            end
            ACT_LYING:
            begin
                lo = bound_reg[REG_LYING_LOW];
                hi = bound_reg[REG_LYING_HIGH];
            end
            default:
            begin
                lo = OTHER_LOW;
                hi = OTHER_HIGH;
            end
        endcase
    endfunction

    // One out-of-bound sample on a channel; alert is set when it fires.
    task automatic advance_channel(inout alarm_channel_t ch, input logic [STAMP_W-1:0] at,
                                   output bit alert);
        logic [STAMP_W-1:0] elapsed;
        alert = 1'b0;
        if (ch.hits != COUNT_MAX)
        begin
            ch.hits++;
        end
        elapsed = at - ch.first_stamp;
        if (ch.hits == 8'd1)
        begin
            ch.first_stamp = at;
        end
        else if (ch.hits == ALERT_COUNT && elapsed <= SUSTAIN_LIMIT)
        begin
            alert = 1'b1;
        end
        else if (elapsed > SUSTAIN_LIMIT)
        begin
            ch.hits = '0;
        end
    endtask

    // Status of one record; updates the predicted channel state.
    task automatic predict_status(input record_t r, output status_pair_t s);
        int lo;
        int hi;
        int pulse;
        int temp;
        int cold;
        int hot;
        bit alert;
        s.pulse       = STAT_NORMAL;
        s.temperature = STAT_NORMAL;
        heart_bounds(r.activity, lo, hi);
        pulse = int'(r.pulse);
        // The low channel wins when a value breaks both bounds.
        if (pulse < lo * 16)
        begin
            advance_channel(low_pulse_ch, r.stamp, alert);
            if (alert)
            begin
                s.pulse = STAT_LOW;
            end
        end
        else if (pulse > hi * 16)
        begin
            advance_channel(high_pulse_ch, r.stamp, alert);
            if (alert)
            begin
                s.pulse = STAT_HIGH;
            end
        end
        temp = int'(r.temperature);
        cold = int'($signed(bound_reg[REG_COLD])) * 16;
        hot  = int'($signed(bound_reg[REG_HOT])) * 16;
        if (temp < cold)
        begin
            advance_channel(cold_ch, r.stamp, alert);
            if (alert)
            begin
                s.temperature = STAT_LOW;
            end
        end
        else if (temp > hot)
        begin
            advance_channel(hot_ch, r.stamp, alert);
            if (alert)
            begin
                s.temperature = STAT_HIGH;
            end
        end
    endtask

    // Pulse value placed relative to the bounds of an activity.
    function automatic logic [VAL_W-1:0] pick_pulse(input logic [ACT_W-1:0] act,
                                                    input aim_t aim);
        int lo;
        int hi;
        heart_bounds(act, lo, hi);
        lo = lo * 16;
        hi = hi * 16;
        case (aim)
            AIM_LOW:
            begin
                if (lo > 0)
                begin
                    return VAL_W'($urandom_range(0, lo - 1));
                end
            end
            AIM_HIGH:
            begin
                return VAL_W'($urandom_range(PULSE_MAX, hi + 1));
            end
            AIM_INSIDE:
            begin
                if (lo <= hi)
                begin
                    return VAL_W'($urandom_range(hi, lo));
                end
            end
            default:
            begin
            end
        endcase
        return VAL_W'($urandom_range(0, PULSE_MAX));
    endfunction

    // Temperature value placed relative to the cold and hot bounds.
    function automatic logic signed [VAL_W-1:0] pick_temperature(input aim_t aim);
        int cold;
        int hot;
        cold = int'($signed(bound_reg[REG_COLD])) * 16;
        hot  = int'($signed(bound_reg[REG_HOT])) * 16;
        case (aim)
            AIM_LOW:
            begin
                if (cold > TEMP_MIN)
                begin
                    return VAL_W'(TEMP_MIN + int'($urandom_range(0, cold - 1 - TEMP_MIN)));
                end
            end
            AIM_HIGH:
            begin
                return VAL_W'(hot + 1 + int'($urandom_range(0, TEMP_MAX - hot - 1)));
            end
            AIM_INSIDE:
            begin
                if (cold <= hot)
                begin
                    return VAL_W'(cold + int'($urandom_range(0, hot - cold)));
                end
            end
            default:
            begin
            end
        endcase
        return VAL_W'($urandom_range(0, PULSE_MAX));
    endfunction

    // Offers one record, waits for its transfer and queues its prediction.
    task automatic send_record(input record_t r);
        status_pair_t want;
        if (!steady_flow && $urandom_range(0, 99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        stamp          <= r.stamp;
        activity_code  <= r.activity;
        pulse_q4       <= r.pulse;
        temperature_q4 <= r.temperature;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_status(r, want);
        expected_status = {expected_status, want};
    endtask

    task automatic send_fields(input logic [STAMP_W-1:0] at, input logic [ACT_W-1:0] act,
                               input logic [VAL_W-1:0] pulse,
                               input logic signed [VAL_W-1:0] temp);
        record_t r;
        r.stamp       = at;
        r.activity    = act;
        r.pulse       = pulse;
        r.temperature = temp;
        send_record(r);
    endtask

    // A run of n records whose stamps spread evenly from base to base + span.
    task automatic send_run(input int n, input logic [STAMP_W-1:0] base, input int span,
                            input logic [ACT_W-1:0] act, input aim_t pulse_aim,
                            input aim_t temp_aim, input bit mix_quiet);
        logic [STAMP_W-1:0] at;
        aim_t pa;
        aim_t ta;
        for (int k = 0; k < n; k++)
        begin
            at = base + STAMP_W'((k * span) / (n - 1));
            pa = pulse_aim;
            ta = temp_aim;
            // An in-range record now and then must leave the channels alone.
            if (mix_quiet && $urandom_range(0, 9) == 0)
            begin
                pa = AIM_INSIDE;
                ta = AIM_INSIDE;
            end
            send_fields(at, act, pick_pulse(act, pa), pick_temperature(ta));
        end
    endtask

    // Lowers valid and waits until every predicted result has been checked.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes all bound registers, then one index that has no register.
    task automatic load_bounds(input bound_set_t vals);
        // Bounds only change while no record is in flight.
        wait_for_results();
        for (int i = REG_LYING_LOW; i <= REG_HOT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            bound_reg[i] = vals[i];
        end
        cfg_index <= REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0,
                     REG_UNUSED_LAST - REG_UNUSED_FIRST));
        cfg_data  <= BOUND_W'($urandom_range(0, 255));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic bound_set_t uniform_bounds(input logic [BOUND_W-1:0] heart_lo,
                                                  input logic [BOUND_W-1:0] heart_hi,
                                                  input logic [BOUND_W-1:0] cold,
                                                  input logic [BOUND_W-1:0] hot);
        bound_set_t b;
        b[REG_LYING_LOW]    = heart_lo;
        b[REG_LYING_HIGH]   = heart_hi;
        b[REG_SEATED_LOW]   = heart_lo;
        b[REG_SEATED_HIGH]  = heart_hi;
        b[REG_WALKING_LOW]  = heart_lo;
        b[REG_WALKING_HIGH] = heart_hi;
        b[REG_COLD]         = cold;
        b[REG_HOT]          = hot;
        return b;
    endfunction

    // Mostly plausible low/high pairs, sometimes anything at all.
    function automatic void random_heart_pair(output logic [BOUND_W-1:0] lo,
                                              output logic [BOUND_W-1:0] hi);
        int base;
        if ($urandom_range(0, 3) == 0)
        begin
            lo = BOUND_W'($urandom_range(0, 255));
            hi = BOUND_W'($urandom_range(0, 255));
        end
        else
        begin
            base = $urandom_range(30, 110);
            lo = BOUND_W'(base);
            hi = BOUND_W'(base + int'($urandom_range(10, 100)));
        end
    endfunction

    function automatic bound_set_t random_bounds();
        bound_set_t b;
        int cold;
        random_heart_pair(b[REG_LYING_LOW], b[REG_LYING_HIGH]);
        random_heart_pair(b[REG_SEATED_LOW], b[REG_SEATED_HIGH]);
        random_heart_pair(b[REG_WALKING_LOW], b[REG_WALKING_HIGH]);
        if ($urandom_range(0, 3) == 0)
        begin
            b[REG_COLD] = BOUND_W'($urandom_range(0, 255));
            b[REG_HOT]  = BOUND_W'($urandom_range(0, 255));
        end
        else
        begin
            cold = int'($urandom_range(0, 30)) - 10;
            b[REG_COLD] = BOUND_W'(cold);
            b[REG_HOT]  = BOUND_W'(cold + int'($urandom_range(5, 30)));
        end
        return b;
    endfunction

    // Result-side stall: random short stalls, or a long hold when requested.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= !steady_flow && ($urandom_range(0, 99) < 6);
        end
    end

    // Compares every result transfer with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        status_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                flag_error("result with nothing pending, pulse_status", 0, pulse_status);
            end
            else
            begin
                want = expected_status.pop_front();
                if (pulse_status !== want.pulse)
                begin
                    flag_error("pulse_status", want.pulse, pulse_status);
                end
                if (temperature_status !== want.temperature)
                begin
                    flag_error("temperature_status", want.temperature, temperature_status);
                end
            end
        end
    end

    // Right after reset all counts are zero, so the window edges are exact.
    task automatic test_sustain_window();
        // Tenth sample exactly at the window edge alerts on low pulse and hot.
        send_run(10, 32'd1000, 30, ACT_LYING, AIM_LOW, AIM_HIGH, 1'b0);
        // One second past the window clears both channels.
        send_fields(32'd1031, ACT_LYING, pick_pulse(ACT_LYING, AIM_LOW),
                    pick_temperature(AIM_HIGH));
        // Tenth sample one second late: no alert, channel cleared.
        send_run(10, 32'd5000, 31, ACT_WALKING, AIM_HIGH, AIM_LOW, 1'b0);
        // Stamps that wrap around zero still measure the window modulo 2^32.
        send_run(10, 32'hFFFF_FFF0, 30, ACT_SITTING, AIM_HIGH, AIM_LOW, 1'b0);
        wait_for_results();
    endtask

    // Enough samples at one stamp to pin the counts at their ceiling.
    task automatic test_count_saturation();
        send_run(262, 32'hFFFF_FFF8, 0, ACT_LYING, AIM_LOW, AIM_HIGH, 1'b0);
        // A saturated count still clears once a sample falls past the window.
        send_fields(32'hFFFF_FFF8 + SUSTAIN_LIMIT + 32'd1, ACT_LYING,
                    pick_pulse(ACT_LYING, AIM_LOW), pick_temperature(AIM_HIGH));
        send_run(10, 32'd40, 12, ACT_LYING, AIM_LOW, AIM_HIGH, 1'b0);
        wait_for_results();
    endtask

    // Field extremes and values at or just past each bound.
    task automatic test_field_extremes();
        int t;
        t = 20000;
        send_fields(32'd0, ACT_WALKING, 12'd0, VAL_W'(TEMP_MIN));
        send_fields(32'hFFFF_FFFF, ACT_LYING, 12'hFFF, VAL_W'(TEMP_MAX));
        send_fields(t, ACT_WALKING, VAL_W'(RST_WALKING_LOW * 16), 12'sd0);
        send_fields(t + 40, ACT_WALKING, VAL_W'(RST_WALKING_LOW * 16 - 1), 12'sd0);
        send_fields(t + 80, ACT_WALKING, VAL_W'(RST_WALKING_HIGH * 16), 12'sd0);
        send_fields(t + 120, ACT_WALKING, VAL_W'(RST_WALKING_HIGH * 16 + 1), 12'sd0);
        send_fields(t + 160, ACT_SITTING, VAL_W'(RST_SEATED_LOW * 16 - 1), 12'sd0);
        send_fields(t + 200, ACT_STANDING, VAL_W'(RST_SEATED_HIGH * 16 + 1), 12'sd0);
        send_fields(t + 240, ACT_LYING, VAL_W'(RST_LYING_LOW * 16), 12'sd0);
        send_fields(t + 280, ACT_LYING, VAL_W'(RST_LYING_HIGH * 16), 12'sd0);
        // Codes beyond lying use the fixed bounds.
        for (int a = ACT_OTHER_FIRST; a <= ACT_OTHER_LAST; a++)
        begin
            send_fields(t + 300 + a, ACT_W'(a), 12'd0, 12'sd0);
            send_fields(t + 320 + a, ACT_W'(a), VAL_W'(OTHER_HIGH * 16 + (a & 1)),
                        12'sd0);
        end
        send_fields(t + 400, ACT_OTHER_FIRST, 12'hFFF, 12'sd0);
        // Temperature right at and just past each bound.
        send_fields(t + 440, ACT_LYING, 12'd1000, VAL_W'(int'($signed(RST_COLD)) * 16));
        send_fields(t + 480, ACT_LYING, 12'd1000, VAL_W'(int'($signed(RST_COLD)) * 16 - 1));
        send_fields(t + 520, ACT_LYING, 12'd1000, VAL_W'(int'($signed(RST_HOT)) * 16));
        send_fields(t + 560, ACT_LYING, 12'd1000, VAL_W'(int'($signed(RST_HOT)) * 16 + 1));
        wait_for_results();
    endtask

    // Bound registers at their extremes, including low bounds above high ones.
    task automatic test_bound_extremes();
        // Pulses below 4080 and temperatures below 2032 break both bounds and count on the low channels.
        load_bounds(uniform_bounds(8'd255, 8'd0, 8'sd127, -8'sd128));
        send_run(12, 32'd70000, 20, ACT_WALKING, AIM_ANY, AIM_ANY, 1'b0);
        send_run(12, 32'd70100, 25, ACT_STANDING, AIM_LOW, AIM_LOW, 1'b0);
        // Widest bounds: only the very top pulse and temperature values can break them.
        load_bounds(uniform_bounds(8'd0, 8'd255, -8'sd128, 8'sd127));
        send_run(11, 32'd80000, 10, ACT_LYING, AIM_HIGH, AIM_HIGH, 1'b0);
        send_fields(32'd80050, ACT_SITTING, 12'd0, VAL_W'(TEMP_MIN));
        send_fields(32'd80051, ACT_WALKING, 12'hFFF, VAL_W'(TEMP_MAX));
        wait_for_results();
    endtask

    // The receiver holds off while records keep coming, then the sender waits.
    task automatic test_stall_pressure();
        load_bounds(DEFAULT_BOUNDS);
        hold_request = 80;
        for (int b = 0; b < 3; b++)
        begin
            send_run(13, $urandom(), 24, ACT_W'($urandom_range(0, 7)),
                     aim_t'($urandom_range(0, 3)), aim_t'($urandom_range(0, 3)), 1'b1);
        end
        wait_for_results();
    endtask

    // Random phases: mostly bursts that can reach an alert, some plain noise.
    task automatic test_random_phases();
        int                 sent;
        int                 n;
        int                 span;
        logic [STAMP_W-1:0] base;
        logic [ACT_W-1:0]   act;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 0)
            begin
                load_bounds(DEFAULT_BOUNDS);
            end
            else
            begin
                load_bounds(random_bounds());
            end
            // The first phase runs with no idling on either side.
            steady_flow = (phase == 0);
            sent = 0;
            while (sent < PHASE_RECORDS)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    n    = $urandom_range(6, 14);
                    base = ($urandom_range(0, 3) == 0) ?
                           32'hFFFF_FFFF - STAMP_W'($urandom_range(0, 40)) : $urandom();
                    span = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 30) :
                           $urandom_range(0, 60);
                    act  = ACT_W'($urandom_range(0, 7));
                    send_run(n, base, span, act, aim_t'($urandom_range(0, 3)),
                             aim_t'($urandom_range(0, 3)), 1'b1);
                end
                else
                begin
                    n = $urandom_range(1, 5);
                    repeat (n)
                    begin
                        send_fields($urandom(), ACT_W'($urandom_range(0, 7)),
                                    VAL_W'($urandom_range(0, PULSE_MAX)),
                                    VAL_W'($urandom_range(0, PULSE_MAX)));
                    end
                end
                sent += n;
            end
            wait_for_results();
        end
        steady_flow = 1'b0;
    endtask

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sustain_window();
        test_count_saturation();
        test_field_extremes();
        test_bound_extremes();
        test_stall_pressure();
        test_random_phases();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/svsa_pkg.sv
rtl/sustained_vital_sign_alarm_top.sv
rtl/svsa_checker.sv
bench/sustained_vital_sign_alarm_top_test.sv
